### src/hbd_pkg.sv
// Shared types, constants and the CRC-8 step for the HDLC byte deframer.
// No dependencies; every other file of the block imports it.
package hbd_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;
    localparam logic [BYTE_W-1:0] MASK_RESET   = 8'h20;
    localparam logic [BYTE_W-1:0] CRC_INIT     = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h8C;

    typedef enum logic [1:0] {
        REG_FLAG   = 2'd0,
        REG_ESCAPE = 2'd1,
        REG_MASK   = 2'd2
    } reg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA    = 3'd0,
        ST_OK      = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_SHORT   = 3'd3,
        ST_CRC_BAD = 3'd4,
        ST_ABORT   = 3'd5,
        ST_BAD_ESC = 3'd6
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] escape_mask;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        status_t           status;
        logic              frame_end;
    } res_t;

    // Reflected CRC-8, one byte per call, unrolled over the eight bits.
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### src/hbd_if.sv
// Valid/ready channel interfaces for the deframer: line bytes in, results out.
// Depends on hbd_pkg for field widths.
interface hbd_in_if;
    import hbd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hbd_out_if;
    import hbd_pkg::*;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   payload_byte;
    logic [STATUS_W-1:0] status;
    logic                frame_end;
    modport source (output valid, output payload_byte, output status, output frame_end,
                    input ready);
    modport sink   (input valid, input payload_byte, input status, input frame_end,
                    output ready);
endinterface

### src/hbd_cfg_regs.sv
// APB-style register file: flag, escape and escape mask bytes.
// Depends on hbd_pkg.
module hbd_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hbd_pkg::ADDR_W-1:0] paddr,
    input  logic [hbd_pkg::DATA_W-1:0] pwdata,
    output logic [hbd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output hbd_pkg::cfg_t              cfg
);
    import hbd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_FLAG:   cfg_next.flag_value   = pwdata[BYTE_W-1:0];
                REG_ESCAPE: cfg_next.escape_value = pwdata[BYTE_W-1:0];
                REG_MASK:   cfg_next.escape_mask  = pwdata[BYTE_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FLAG:   prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_reg.flag_value};
            REG_ESCAPE: prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_reg.escape_value};
            REG_MASK:   prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_reg.escape_mask};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value   <= FLAG_RESET;
            cfg_reg.escape_value <= ESCAPE_RESET;
            cfg_reg.escape_mask  <= MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/hbd_core.sv
// Input register, frame state and per-byte decode with the CRC-8 update.
// Depends on hbd_pkg; feeds hbd_out_stage.
module hbd_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hbd_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    input  logic [hbd_pkg::BYTE_W-1:0] in_byte,
    output logic                       in_ready,
    input  logic                       out_free,
    output logic                       res_load,
    output hbd_pkg::res_t              res
);
    import hbd_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg,  in_byte_next;

    logic              in_frame_reg,   in_frame_next;
    logic              esc_pend_reg,   esc_pend_next;
    logic [BYTE_W-1:0] held_byte_reg,  held_byte_next;
    logic              held_valid_reg, held_valid_next;
    logic              any_emit_reg,   any_emit_next;
    logic [BYTE_W-1:0] crc_reg,        crc_next;

    logic              res_valid;
    logic              advance;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] d;

    assign b = in_byte_reg;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        esc_pend_next   = esc_pend_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        any_emit_next   = any_emit_reg;
        crc_next        = crc_reg;
        res             = '{payload_byte: '0, status: ST_DATA, frame_end: 1'b0};
        res_valid       = 1'b0;
        d               = esc_pend_reg ? (b ^ cfg.escape_mask) : b;

        if (in_valid_reg)
        begin
            if (!in_frame_reg)
            begin
                // outside a frame only a flag matters
                if (b == cfg.flag_value)
                begin
                    in_frame_next   = 1'b1;
                    esc_pend_next   = 1'b0;
                    held_valid_next = 1'b0;
                    any_emit_next   = 1'b0;
                    crc_next        = CRC_INIT;
                end
            end
            else if (!esc_pend_reg && b == cfg.flag_value)
            begin
                in_frame_next = 1'b0;
                esc_pend_next = 1'b0;
                res_valid     = 1'b1;
                res.frame_end = 1'b1;
                if (!held_valid_reg)
                begin
                    res.status = ST_EMPTY;
                end
                else if (!any_emit_reg)
                begin
                    res.status = ST_SHORT;
                end
                else if (held_byte_reg == crc_reg)
                begin
                    res.status = ST_OK;
                end
                else
                begin
                    res.status = ST_CRC_BAD;
                end
            end
            else if (!esc_pend_reg && b == cfg.escape_value)
            begin
                esc_pend_next = 1'b1;
            end
            else if (esc_pend_reg && b == cfg.flag_value)
            begin
                esc_pend_next = 1'b0;
                in_frame_next = 1'b0;
                res_valid     = 1'b1;
                res.status    = ST_ABORT;
                res.frame_end = 1'b1;
            end
            else
            begin
                esc_pend_next = 1'b0;
                if (esc_pend_reg && d != cfg.escape_value && d != cfg.flag_value)
                begin
                    // drop the byte, keep the frame open
                    res_valid  = 1'b1;
                    res.status = ST_BAD_ESC;
                end
                else if (held_valid_reg)
                begin
                    // release the held byte, hold the new one as check candidate
                    crc_next         = crc8_update(crc_reg, held_byte_reg);
                    any_emit_next    = 1'b1;
                    held_byte_next   = d;
                    res_valid        = 1'b1;
                    res.payload_byte = held_byte_reg;
                end
                else
                begin
                    held_byte_next  = d;
                    held_valid_next = 1'b1;
                end
            end
        end
    end

    assign advance  = in_valid_reg && (out_free || !res_valid);
    assign res_load = advance && res_valid;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = in_byte;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_frame_reg   <= 1'b0;
            esc_pend_reg   <= 1'b0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            any_emit_reg   <= 1'b0;
            crc_reg        <= CRC_INIT;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                in_frame_reg   <= in_frame_next;
                esc_pend_reg   <= esc_pend_next;
                held_byte_reg  <= held_byte_next;
                held_valid_reg <= held_valid_next;
                any_emit_reg   <= any_emit_next;
                crc_reg        <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

endmodule

### src/hbd_out_stage.sv
// Result register between the decode logic and the output channel.
// Depends on hbd_pkg.
module hbd_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_load,
    input  hbd_pkg::res_t res,
    input  logic          out_ready,
    output logic          out_valid,
    output logic          out_free,
    output hbd_pkg::res_t out_res
);
    import hbd_pkg::*;

    logic out_valid_reg, out_valid_next;
    res_t res_reg,       res_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            res_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### src/hdlc_byte_deframer_crc8.sv
// HDLC byte deframer with reflected CRC-8 check (poly 0x8C, init 0xFF).
//
// in_ch carries received line bytes; out_ch carries one result per data byte,
// frame close, abort or bad escape: payload_byte (data only), status and
// frame_end. Bytes outside a frame, opening flags, escape prefixes and the
// first byte of a frame give no result. Each data byte leaves one byte late,
// since the newest byte is held as the check candidate.
// A result passes through the input register, then the result register, before
// it shows on out_ch.
// Throughput: one byte per cycle unless the receiver stalls; the byte-wide CRC
// update sits between the two registers.
// If the receiver stalls, a result waits in the result register while the
// next byte still enters the input register; further bytes are held off only
// when that byte also has a result to deliver.
// Reset clears the frame state, both registers' valid flags and restores the
// flag, escape and mask registers to 0x7E, 0x7D and 0x20. The APB port writes
// registers at byte addresses 0, 4 and 8; write them only while idle.
module hdlc_byte_deframer_crc8 (
    input  logic                       clk,
    input  logic                       rst_n,
    hbd_in_if.sink                     in_ch,
    hbd_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hbd_pkg::ADDR_W-1:0] paddr,
    input  logic [hbd_pkg::DATA_W-1:0] pwdata,
    output logic [hbd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import hbd_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t out_res;
    logic res_load;
    logic out_free;

    hbd_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_ch.valid),
        .in_byte  (in_ch.rx_byte),
        .in_ready (in_ch.ready),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    hbd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_free  (out_free),
        .out_res   (out_res)
    );

    assign out_ch.payload_byte = out_res.payload_byte;
    assign out_ch.status       = out_res.status;
    assign out_ch.frame_end    = out_res.frame_end;

endmodule

### src/hbd_checker.sv
// Port-level checks on the deframer's result channel, bound to the top level.
// Depends on hbd_pkg and hdlc_byte_deframer_crc8.
module hbd_port_props (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [hbd_pkg::BYTE_W-1:0]   payload_byte,
    input  logic [hbd_pkg::STATUS_W-1:0] status,
    input  logic                         frame_end
);
    import hbd_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_byte))
        else $error("result dropped or changed while stalled");

    a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |->
            status == ST_OK || status == ST_EMPTY || status == ST_SHORT ||
            status == ST_CRC_BAD || status == ST_ABORT)
        else $error("frame end with a non-closing status");

    a_open_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_end |-> status == ST_DATA || status == ST_BAD_ESC)
        else $error("closing status without frame end");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DATA |-> payload_byte == '0)
        else $error("payload set on a status result");

endmodule

bind hdlc_byte_deframer_crc8 hbd_port_props u_hbd_port_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .payload_byte (out_ch.payload_byte),
    .status       (out_ch.status),
    .frame_end    (out_ch.frame_end)
);

### test/hbd_checker.sv
`timescale 1ns / 1ps
// Checker for the HDLC byte deframer: follows the APB writes and both channels,
// predicts each result and compares it field by field. Depends on hbd_pkg and hbd_if.
module hbd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    hbd_in_if                          in_ch,
    hbd_out_if                         out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [hbd_pkg::ADDR_W-1:0] paddr,
    input  logic [hbd_pkg::DATA_W-1:0] pwdata,
    output int                         mismatches,
    output int                         awaiting
);
    import hbd_pkg::*;

    localparam logic [7:0] FCS_SEED = 8'hFF;
    localparam logic [7:0] FCS_POLY = 8'h8C;

    cfg_t       cfg;
    logic       in_frame;
    logic       esc_pending;
    logic [7:0] held_byte;
    logic       held_valid;
    logic       any_released;
    logic [7:0] fcs;
    res_t       deframer_results[$];

    function automatic logic [7:0] fcs8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advance the frame state by one line byte; return 1 when it yields a result.
    function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
        logic [7:0] d;
        r.payload_byte = 8'h00;
        r.status       = ST_DATA;
        r.frame_end    = 1'b0;
        if (!in_frame)
        begin
            if (b == cfg.flag_value)
            begin
                in_frame     = 1'b1;
                esc_pending  = 1'b0;
                held_valid   = 1'b0;
                any_released = 1'b0;
                fcs          = FCS_SEED;
            end
            return 1'b0;
        end
        if (!esc_pending && b == cfg.flag_value)
        begin
            in_frame    = 1'b0;
            r.frame_end = 1'b1;
            if (!held_valid)
                r.status = ST_EMPTY;
            else if (!any_released)
                r.status = ST_SHORT;
            else if (held_byte == fcs)
                r.status = ST_OK;
            else
                r.status = ST_CRC_BAD;
            return 1'b1;
        end
        if (!esc_pending && b == cfg.escape_value)
        begin
            esc_pending = 1'b1;
            return 1'b0;
        end
        d = b;
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            if (b == cfg.flag_value)
            begin
                in_frame    = 1'b0;
                r.status    = ST_ABORT;
                r.frame_end = 1'b1;
                return 1'b1;
            end
            d = b ^ cfg.escape_mask;
            // drop a byte that decodes to neither flag nor escape
            if (d != cfg.escape_value && d != cfg.flag_value)
            begin
                r.status = ST_BAD_ESC;
                return 1'b1;
            end
        end
        if (held_valid)
        begin
            r.payload_byte = held_byte;
            fcs            = fcs8_next(fcs, held_byte);
            any_released   = 1'b1;
            held_byte      = d;
            return 1'b1;
        end
        held_byte  = d;
        held_valid = 1'b1;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t fresh;
        if (!rst_n)
        begin
            cfg.flag_value   = FLAG_RESET;
            cfg.escape_value = ESCAPE_RESET;
            cfg.escape_mask  = MASK_RESET;
            in_frame         = 1'b0;
            esc_pending      = 1'b0;
            held_byte        = 8'h00;
            held_valid       = 1'b0;
            any_released     = 1'b0;
            fcs              = FCS_SEED;
            deframer_results.delete();
            mismatches       = 0;
            awaiting         = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_FLAG:   cfg.flag_value   = pwdata[7:0];
                    REG_ESCAPE: cfg.escape_value = pwdata[7:0];
                    REG_MASK:   cfg.escape_mask  = pwdata[7:0];
                    default:    ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (deframer_results.size() == 0)
                begin
                    $error("unexpected result: payload_byte %h status %0d frame_end %0b",
                           out_ch.payload_byte, out_ch.status, out_ch.frame_end);
                    mismatches++;
                end
                else
                begin
                    want = deframer_results.pop_front();
                    if (out_ch.payload_byte !== want.payload_byte)
                    begin
                        $error("payload_byte: expected %h, got %h",
                               want.payload_byte, out_ch.payload_byte);
                        mismatches++;
                    end
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        mismatches++;
                    end
                    if (out_ch.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, out_ch.frame_end);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (deframe_byte(in_ch.rx_byte, fresh))
                    deframer_results = {deframer_results, fresh};
            end
            awaiting = deframer_results.size();
        end
    end

endmodule

### test/tb_hdlc_byte_deframer_crc8.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, APB writes, line byte frames and verdict.
// Depends on hbd_pkg, hbd_if, the deframer RTL and hbd_checker.
module tb_hdlc_byte_deframer_crc8;
    import hbd_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [7:0] FCS_SEED    = 8'hFF;
    localparam logic [7:0] FCS_POLY    = 8'h8C;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int          mismatches;
    int          awaiting;
    int unsigned cycles  = 0;
    bit          no_gaps = 1'b0;
    logic [7:0]  flag_byte = FLAG_RESET;
    logic [7:0]  esc_byte  = ESCAPE_RESET;
    logic [7:0]  mask_byte = MASK_RESET;
    logic [7:0]  line_q[$];

    hbd_in_if  in_ch ();
    hbd_out_if out_ch ();

    hdlc_byte_deframer_crc8 uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hbd_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 16);
        end
    end

    function automatic logic [7:0] fcs8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {24'($urandom), v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_FLAG:   flag_byte = v;
            REG_ESCAPE: esc_byte  = v;
            REG_MASK:   mask_byte = v;
            default:    ;
        endcase
    endtask

    task automatic add_line_byte(input logic [7:0] b);
        line_q = {line_q, b};
    endtask

    // Append a data byte, escaping it when it collides with flag or escape.
    task automatic put_stuffed(input logic [7:0] b);
        if (b == flag_byte || b == esc_byte)
        begin
            add_line_byte(esc_byte);
            add_line_byte(b ^ mask_byte);
        end
        else
        begin
            add_line_byte(b);
        end
    endtask

    // Send the queued line bytes; valid stays high into the next call.
    task automatic send_line();
        foreach (line_q[i])
        begin
            while (!no_gaps && $urandom_range(0, 99) < 16)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.rx_byte <= line_q[i];
            @(posedge clk);
            while (!in_ch.ready) @(posedge clk);
            @(negedge clk);
        end
        line_q.delete();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [7:0] f, input logic [7:0] e, input logic [7:0] m,
                             input bit quiet);
        int         n;
        int         sent;
        logic [7:0] crc;
        logic [7:0] b;
        wait_drained();
        write_reg(REG_FLAG, f);
        write_reg(REG_ESCAPE, e);
        write_reg(REG_MASK, m);
        no_gaps = quiet;
        sent    = 0;
        while (sent < 70)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) add_line_byte(8'($urandom));
            add_line_byte(flag_byte);
            n   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
            crc = FCS_SEED;
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       b = flag_byte;
                    1:       b = esc_byte;
                    default: b = 8'($urandom);
                endcase
                put_stuffed(b);
                crc = fcs8_next(crc, b);
            end
            // an empty payload sometimes still carries a check byte
            if (n > 0 || $urandom_range(0, 1) == 1)
                put_stuffed(($urandom_range(0, 3) == 0) ? 8'($urandom) : crc);
            case ($urandom_range(0, 19))
                0:
                begin
                    add_line_byte(esc_byte);
                    add_line_byte(8'($urandom));
                    add_line_byte(flag_byte);
                end
                1:
                begin
                    add_line_byte(esc_byte);
                    add_line_byte(flag_byte);
                end
                2:       ;
                default: add_line_byte(flag_byte);
            endcase
            sent += line_q.size();
            send_line();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        logic [7:0] crc;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // outside a frame, empty frame, too short, escaped flag
        line_q = '{8'h00, 8'hFF, flag_byte, flag_byte, flag_byte, 8'h55, flag_byte,
                   flag_byte, esc_byte, flag_byte};
        // bad escape inside a frame that still closes with a good check byte
        add_line_byte(flag_byte);
        add_line_byte(esc_byte);
        add_line_byte(8'h41);
        put_stuffed(8'h00);
        put_stuffed(8'hFF);
        put_stuffed(flag_byte);
        put_stuffed(esc_byte);
        crc = fcs8_next(fcs8_next(fcs8_next(fcs8_next(FCS_SEED, 8'h00), 8'hFF),
                                  flag_byte), esc_byte);
        put_stuffed(crc);
        add_line_byte(flag_byte);
        // check byte off by one bit
        add_line_byte(flag_byte);
        put_stuffed(8'h80);
        put_stuffed(fcs8_next(FCS_SEED, 8'h80) ^ 8'h01);
        add_line_byte(flag_byte);
        send_line();

        run_phase(FLAG_RESET, ESCAPE_RESET, MASK_RESET, 1'b0);
        run_phase(8'h00, 8'hFF, 8'hFF, 1'b0);
        run_phase(8'hFF, 8'h00, 8'h00, 1'b1);
        run_phase(8'h5A, 8'h5A, 8'h01, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
